// ----- rtl/hcf_pkg.sv -----
// Package with the widths, codes and shared types of the Harris corner frame block.
package hcf_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int X_W         = $clog2(MAX_WIDTH);
  localparam int Y_W         = $clog2(MAX_HEIGHT);

  localparam int DIM_W      = 9;
  localparam int THR_W      = 8;
  localparam int K_W        = 16;
  localparam int K_FRAC     = 16;
  localparam int PIX_W      = 8;
  localparam int RSP_OUT_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int GRAD_W  = 11;
  localparam int SQ_W    = 20;
  localparam int XY_W    = 21;
  localparam int SUM_W   = 24;
  localparam int CSUM_W  = 25;
  localparam int DET_W   = 2 * SUM_W + 1;
  localparam int T2_W    = 2 * (SUM_W + 1);
  localparam int KHI_W   = K_W + T2_W - K_FRAC;
  localparam int RESP_W  = 51;
  localparam int QUO_W   = 9;
  localparam int ITER_W  = $clog2(QUO_W);
  localparam int NUM_W   = RESP_W + QUO_W + 1;
  localparam int D255_W  = RESP_W + THR_W;

  localparam logic [DIM_W-1:0] RST_WIDTH     = 9'd256;
  localparam logic [DIM_W-1:0] RST_HEIGHT    = 9'd256;
  localparam logic [DIM_W-1:0] MIN_DIM       = 9'd3;
  localparam logic [THR_W-1:0] RST_THRESHOLD = 8'd120;
  localparam logic [K_W-1:0]   RST_HARRIS_K  = 16'd2621;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_HARRIS_K  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_FETCH = 1'b1
  } act_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_P1_TAP,
    S_P1_DRAIN,
    S_P1_WRITE,
    S_P2_TAP,
    S_P2_DRAIN,
    S_P2_M1,
    S_P2_M2,
    S_P2_M3,
    S_P2_M4,
    S_P2_WRITE,
    S_FINISH,
    S_F_DIFF,
    S_F_PREP,
    S_F_DIV,
    S_F_OUT
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_TAP1,
    OP_WR1,
    OP_TAP2,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_M4,
    OP_WR2,
    OP_FIN,
    OP_DIFF,
    OP_PREP,
    OP_DIV,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic frame_ready;
    logic load_final;
    logic tap_last;
    logic pix_last;
    logic div_last;
    logic out_free;
  } hcf_status_t;

endpackage

// ----- rtl/hcf_if.sv -----
// Channel interfaces for pixel beats, result beats and register writes.
interface hcf_pix_if import hcf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] pixel;
  modport source(output valid, action, pixel, input ready);
  modport sink(input valid, action, pixel, output ready);
endinterface

interface hcf_res_if import hcf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RSP_OUT_W-1:0] response;
  logic                 is_corner;
  logic                 last;
  modport source(output valid, response, is_corner, last, input ready);
  modport sink(input valid, response, is_corner, last, output ready);
endinterface

interface hcf_cfg_if import hcf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/hcf_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module hcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/hcf_ctrl.sv -----
// Controller state machine sequencing load, compute passes and fetch division.
module hcf_ctrl import hcf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        action,
  output logic        in_ready,
  input  hcf_status_t st,
  output dp_op_t      op
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (act_t'(action) == ACT_LOAD) begin
            if (!st.frame_ready) begin
              op = OP_LOAD;
              if (st.load_final) begin
                state_next = S_P1_TAP;
              end
            end
          end else if (st.frame_ready) begin
            state_next = S_F_DIFF;
          end
        end
      end
      S_P1_TAP: begin
        op = OP_TAP1;
        if (st.tap_last) begin
          state_next = S_P1_DRAIN;
        end
      end
      S_P1_DRAIN: state_next = S_P1_WRITE;
      S_P1_WRITE: begin
        op         = OP_WR1;
        state_next = st.pix_last ? S_P2_TAP : S_P1_TAP;
      end
      S_P2_TAP: begin
        op = OP_TAP2;
        if (st.tap_last) begin
          state_next = S_P2_DRAIN;
        end
      end
      S_P2_DRAIN: state_next = S_P2_M1;
      S_P2_M1: begin
        op         = OP_M1;
        state_next = S_P2_M2;
      end
      S_P2_M2: begin
        op         = OP_M2;
        state_next = S_P2_M3;
      end
      S_P2_M3: begin
        op         = OP_M3;
        state_next = S_P2_M4;
      end
      S_P2_M4: begin
        op         = OP_M4;
        state_next = S_P2_WRITE;
      end
      S_P2_WRITE: begin
        op         = OP_WR2;
        state_next = st.pix_last ? S_FINISH : S_P2_TAP;
      end
      S_FINISH: begin
        op         = OP_FIN;
        state_next = S_IDLE;
      end
      S_F_DIFF: begin
        op         = OP_DIFF;
        state_next = S_F_PREP;
      end
      S_F_PREP: begin
        op         = OP_PREP;
        state_next = S_F_DIV;
      end
      S_F_DIV: begin
        op = OP_DIV;
        if (st.div_last) begin
          state_next = S_F_OUT;
        end
      end
      S_F_OUT: begin
        if (st.out_free) begin
          op         = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/hcf_dp.sv -----
// Datapath with frame stores, Sobel and smoothing accumulators, response math and divider.
module hcf_dp import hcf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_op_t                op,
  output hcf_status_t           st,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [RSP_OUT_W-1:0]  out_response,
  output logic                  out_is_corner,
  output logic                  out_last
);

  logic [DIM_W-1:0] reg_width, reg_height;
  logic [THR_W-1:0] reg_thr;
  logic [K_W-1:0]   reg_k;

  logic [DIM_W-1:0]     w_c, h_c, fw, fh;
  logic [2*DIM_W-1:0]   area;
  logic [COUNT_W-1:0]   total, load_count, lc_eff, lc_next, frame_total, read_count;
  logic                 frame_ready;

  logic [X_W-1:0]       px;
  logic [Y_W-1:0]       py;
  logic [ADDR_W-1:0]    pidx;
  logic [1:0]           dx, dy, dxd, dyd;
  logic                 acc1_en, acc2_en, acc_first;
  logic [DIM_W-1:0]     rx9, ry9;
  logic [Y_W+DIM_W-1:0] row_base;
  logic [ADDR_W-1:0]    tap_addr;
  logic                 pix_last;

  logic [PIX_W-1:0]     pix_rd;
  logic [SQ_W-1:0]      xx_rd, yy_rd;
  logic [XY_W-1:0]      xy_rd;
  logic [RESP_W-1:0]    rsp_rd;

  logic signed [GRAD_W-1:0]   gx, gy, pv, pv_x, pv_y, tx, ty;
  logic signed [2*GRAD_W-1:0] pxx, pyy, pxy;
  logic [1:0]                 sh;
  logic [SUM_W-1:0]           a, b, txx, tyy;
  logic signed [CSUM_W-1:0]   c, txy;
  logic signed [2*CSUM_W-1:0] csq;
  logic [2*SUM_W-1:0]         ab, cc;
  logic [SUM_W:0]             tsum;
  logic [T2_W-1:0]            t2;
  logic [DET_W-1:0]           det;
  logic [KHI_W-1:0]           khi;
  logic [2*K_W-1:0]           klo;
  logic [RESP_W-1:0]          resp, rmin, rmax, range, diff;

  logic [NUM_W-1:0]  rem, dsh;
  logic [QUO_W-1:0]  q;
  logic [ITER_W-1:0] iter;
  logic [D255_W-1:0] d255, thr_rng;
  logic              corner;
  logic              is_last;

  assign w_c = (reg_width < MIN_DIM) ? MIN_DIM :
               (reg_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : reg_width;
  assign h_c = (reg_height < MIN_DIM) ? MIN_DIM :
               (reg_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : reg_height;
  assign area    = w_c * h_c;
  assign total   = area[COUNT_W-1:0];
  assign lc_eff  = (load_count >= total) ? '0 : load_count;
  assign lc_next = lc_eff + COUNT_W'(1);

  always_comb begin
    if (px == '0 && dx == 2'd0) begin
      rx9 = DIM_W'(1);
    end else if (DIM_W'(px) == fw - DIM_W'(1) && dx == 2'd2) begin
      rx9 = fw - DIM_W'(2);
    end else begin
      rx9 = DIM_W'(px) + DIM_W'(dx) - DIM_W'(1);
    end
    if (py == '0 && dy == 2'd0) begin
      ry9 = DIM_W'(1);
    end else if (DIM_W'(py) == fh - DIM_W'(1) && dy == 2'd2) begin
      ry9 = fh - DIM_W'(2);
    end else begin
      ry9 = DIM_W'(py) + DIM_W'(dy) - DIM_W'(1);
    end
  end

  assign row_base = ry9[Y_W-1:0] * fw;
  assign tap_addr = row_base[ADDR_W-1:0] + ADDR_W'(rx9[X_W-1:0]);
  assign pix_last = (COUNT_W'(pidx) + COUNT_W'(1)) == frame_total;
  assign is_last  = (read_count + COUNT_W'(1)) == frame_total;

  hcf_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_pix_ram (
    .clk(clk), .we(op == OP_LOAD), .waddr(lc_eff[ADDR_W-1:0]), .wdata(pixel),
    .raddr(tap_addr), .rdata(pix_rd)
  );

  assign pxx = gx * gx;
  assign pyy = gy * gy;
  assign pxy = gx * gy;

  hcf_ram #(.WIDTH(SQ_W), .DEPTH(STORE_DEPTH)) u_xx_ram (
    .clk(clk), .we(op == OP_WR1), .waddr(pidx), .wdata(pxx[SQ_W-1:0]),
    .raddr(tap_addr), .rdata(xx_rd)
  );

  hcf_ram #(.WIDTH(SQ_W), .DEPTH(STORE_DEPTH)) u_yy_ram (
    .clk(clk), .we(op == OP_WR1), .waddr(pidx), .wdata(pyy[SQ_W-1:0]),
    .raddr(tap_addr), .rdata(yy_rd)
  );

  hcf_ram #(.WIDTH(XY_W), .DEPTH(STORE_DEPTH)) u_xy_ram (
    .clk(clk), .we(op == OP_WR1), .waddr(pidx), .wdata(pxy[XY_W-1:0]),
    .raddr(tap_addr), .rdata(xy_rd)
  );

  hcf_ram #(.WIDTH(RESP_W), .DEPTH(STORE_DEPTH)) u_rsp_ram (
    .clk(clk), .we(op == OP_WR2), .waddr(pidx), .wdata(resp),
    .raddr(read_count[ADDR_W-1:0]), .rdata(rsp_rd)
  );

  // Sobel taps: the center column and row carry weight two.
  always_comb begin
    pv   = $signed({{(GRAD_W-PIX_W){1'b0}}, pix_rd});
    pv_x = (dyd == 2'd1) ? (pv <<< 1) : pv;
    pv_y = (dxd == 2'd1) ? (pv <<< 1) : pv;
    tx   = (dxd == 2'd0) ? -pv_x : (dxd == 2'd2) ? pv_x : '0;
    ty   = (dyd == 2'd0) ? -pv_y : (dyd == 2'd2) ? pv_y : '0;
    sh   = {1'b0, dyd == 2'd1} + {1'b0, dxd == 2'd1};
    txx  = SUM_W'(xx_rd) << sh;
    tyy  = SUM_W'(yy_rd) << sh;
    txy  = $signed({{(CSUM_W-XY_W){xy_rd[XY_W-1]}}, xy_rd}) <<< sh;
  end

  assign csq = c * c;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width   <= RST_WIDTH;
      reg_height  <= RST_HEIGHT;
      reg_thr     <= RST_THRESHOLD;
      reg_k       <= RST_HARRIS_K;
      load_count  <= '0;
      read_count  <= '0;
      frame_total <= '0;
      frame_ready <= 1'b0;
      px          <= '0;
      py          <= '0;
      pidx        <= '0;
      dx          <= '0;
      dy          <= '0;
      acc1_en     <= 1'b0;
      acc2_en     <= 1'b0;
      iter        <= '0;
      rmin        <= '0;
      rmax        <= '0;
      out_valid   <= 1'b0;
    end else begin
      acc1_en   <= (op == OP_TAP1);
      acc2_en   <= (op == OP_TAP2);
      acc_first <= (dx == 2'd0) && (dy == 2'd0);
      dxd       <= dx;
      dyd       <= dy;

      if (acc1_en) begin
        gx <= acc_first ? tx : gx + tx;
        gy <= acc_first ? ty : gy + ty;
      end
      if (acc2_en) begin
        a <= acc_first ? txx : a + txx;
        b <= acc_first ? tyy : b + tyy;
        c <= acc_first ? txy : c + txy;
      end

      if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (op)
        OP_LOAD: begin
          if (lc_next >= total) begin
            load_count  <= '0;
            fw          <= w_c;
            fh          <= h_c;
            frame_total <= total;
            px          <= '0;
            py          <= '0;
            pidx        <= '0;
          end else begin
            load_count <= lc_next;
          end
        end
        OP_TAP1, OP_TAP2: begin
          if (dx == 2'd2) begin
            dx <= '0;
            dy <= (dy == 2'd2) ? 2'd0 : dy + 2'd1;
          end else begin
            dx <= dx + 2'd1;
          end
        end
        OP_WR1, OP_WR2: begin
          if (op == OP_WR2) begin
            if (pidx == '0 || $signed(resp) < $signed(rmin)) begin
              rmin <= resp;
            end
            if (pidx == '0 || $signed(resp) > $signed(rmax)) begin
              rmax <= resp;
            end
          end
          if (pix_last) begin
            px   <= '0;
            py   <= '0;
            pidx <= '0;
          end else begin
            pidx <= pidx + ADDR_W'(1);
            if (DIM_W'(px) == fw - DIM_W'(1)) begin
              px <= '0;
              py <= py + Y_W'(1);
            end else begin
              px <= px + X_W'(1);
            end
          end
        end
        OP_M1: begin
          ab   <= a * b;
          cc   <= csq[2*SUM_W-1:0];
          tsum <= {1'b0, a} + {1'b0, b};
        end
        OP_M2: begin
          det <= {1'b0, ab} - {1'b0, cc};
          t2  <= tsum * tsum;
        end
        OP_M3: begin
          khi <= reg_k * t2[T2_W-1:K_FRAC];
          klo <= reg_k * t2[K_FRAC-1:0];
        end
        OP_M4: begin
          resp <= {{(RESP_W-DET_W){det[DET_W-1]}}, det} - RESP_W'(khi)
                  - RESP_W'(klo[2*K_W-1:K_FRAC]);
        end
        OP_FIN: begin
          range       <= rmax - rmin;
          frame_ready <= 1'b1;
          read_count  <= '0;
        end
        OP_DIFF: begin
          diff <= rsp_rd - rmin;
        end
        OP_PREP: begin
          rem     <= NUM_W'({diff, 9'b0}) - NUM_W'({diff, 1'b0}) + NUM_W'(range);
          dsh     <= NUM_W'(range) << QUO_W;
          d255    <= D255_W'({diff, 8'b0}) - D255_W'(diff);
          thr_rng <= reg_thr * range;
          iter    <= ITER_W'(QUO_W - 1);
          q       <= '0;
        end
        OP_DIV: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            q   <= {q[QUO_W-2:0], 1'b1};
          end else begin
            q   <= {q[QUO_W-2:0], 1'b0};
          end
          dsh    <= dsh >> 1;
          iter   <= iter - ITER_W'(1);
          corner <= d255 > thr_rng;
        end
        OP_OUT: begin
          out_valid     <= 1'b1;
          out_response  <= (range == '0) ? '0 : (q[QUO_W-1] ? '1 : q[RSP_OUT_W-1:0]);
          out_is_corner <= (range != '0) && corner;
          out_last      <= is_last;
          if (is_last) begin
            read_count  <= '0;
            frame_ready <= 1'b0;
          end else begin
            read_count <= read_count + COUNT_W'(1);
          end
        end
        default: ;
      endcase

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_WIDTH:     reg_width  <= cfg_data[DIM_W-1:0];
          REG_HEIGHT:    reg_height <= cfg_data[DIM_W-1:0];
          REG_THRESHOLD: reg_thr    <= cfg_data[THR_W-1:0];
          REG_HARRIS_K:  reg_k      <= cfg_data[K_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign st.frame_ready = frame_ready;
  assign st.load_final  = lc_next >= total;
  assign st.tap_last    = (dx == 2'd2) && (dy == 2'd2);
  assign st.pix_last    = pix_last;
  assign st.div_last    = (iter == '0);
  assign st.out_free    = !out_valid || out_ready;

endmodule

// ----- rtl/harris_corner_frame.sv -----
// Top level of the Harris corner frame block: controller, datapath and channel ports.
// Load beats are stored while idle; the beat that completes a frame starts a compute pass
// over the frame (9 store reads per pixel and pass), with no beat taken.
// A fetch beat runs through difference, preparation, the 9-step restoring divider for the
// normalization and an output step that waits for a free result slot, with no beat taken.
// Synchronous active-high rst clears control state and restores register defaults.
module harris_corner_frame import hcf_pkg::*; (
  input logic      clk,
  input logic      rst,
  hcf_pix_if.sink  feed,
  hcf_res_if.source result,
  hcf_cfg_if.sink  cfg
);

  hcf_status_t st;
  dp_op_t      op;

  assign cfg.ready = 1'b1;

  hcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .action   (feed.action),
    .in_ready (feed.ready),
    .st       (st),
    .op       (op)
  );

  hcf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .st            (st),
    .pixel         (feed.pixel),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .out_response  (result.response),
    .out_is_corner (result.is_corner),
    .out_last      (result.last)
  );

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (op == OP_OUT) |-> st.out_free)
    else $error("result beat overwritten before it was taken");

  a_load_when_open: assert property (@(posedge clk) disable iff (rst)
    (op == OP_LOAD) |-> !st.frame_ready)
    else $error("pixel stored while a computed frame is pending");

  a_result_from_fetch: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(op == OP_OUT))
    else $error("result beat raised without a finished fetch");

endmodule
